// File: design/c8_pkg.sv
package c8_pkg;

  localparam int MEMORY_BYTES      = 4096;
  localparam int MEM_AW            = 12;
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int PROGRAM_START_DEF = 512;
  localparam int DISP_ROWS         = 32;
  localparam int GLYPH_BYTES       = 80;

  localparam logic [11:0] FONT_RESET_BASE = 12'd80;
  localparam logic [11:0] PC_LAST         = 12'd4094;
  localparam logic [15:0] INDEX_LIMIT     = 16'h0FFF;
  localparam logic [3:0]  VF_IDX          = 4'hF;

  // item opcodes
  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_EXECUTE   = 3'd1,
    OP_TICK      = 3'd2,
    OP_KEY       = 3'd3,
    OP_READ_DISP = 3'd4,
    OP_READ_MEM  = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_KEY_WAIT  = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_UNDERFLOW = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SHIFT   = 2'd0;
  localparam logic [1:0] CFG_ADVANCE = 2'd1;
  localparam logic [1:0] CFG_FONT    = 2'd2;

  // instruction groups, top nibble
  localparam logic [3:0] G_SYS     = 4'h0;
  localparam logic [3:0] G_JP      = 4'h1;
  localparam logic [3:0] G_CALL    = 4'h2;
  localparam logic [3:0] G_SE_IMM  = 4'h3;
  localparam logic [3:0] G_SNE_IMM = 4'h4;
  localparam logic [3:0] G_SE_REG  = 4'h5;
  localparam logic [3:0] G_LD_IMM  = 4'h6;
  localparam logic [3:0] G_ADD_IMM = 4'h7;
  localparam logic [3:0] G_ALU     = 4'h8;
  localparam logic [3:0] G_SNE_REG = 4'h9;
  localparam logic [3:0] G_LD_I    = 4'hA;
  localparam logic [3:0] G_JP_V0   = 4'hB;
  localparam logic [3:0] G_RND     = 4'hC;
  localparam logic [3:0] G_DRW     = 4'hD;
  localparam logic [3:0] G_KEY     = 4'hE;
  localparam logic [3:0] G_MISC    = 4'hF;

  localparam logic [15:0] W_CLS = 16'h00E0;
  localparam logic [15:0] W_RET = 16'h00EE;

  localparam logic [7:0] E_SKP  = 8'h9E;
  localparam logic [7:0] E_SKNP = 8'hA1;

  localparam logic [7:0] F_LD_DT    = 8'h07;
  localparam logic [7:0] F_WAIT_KEY = 8'h0A;
  localparam logic [7:0] F_SET_DT   = 8'h15;
  localparam logic [7:0] F_SET_ST   = 8'h18;
  localparam logic [7:0] F_ADD_I    = 8'h1E;
  localparam logic [7:0] F_FONT     = 8'h29;
  localparam logic [7:0] F_BCD      = 8'h33;
  localparam logic [7:0] F_STORE    = 8'h55;
  localparam logic [7:0] F_LOAD     = 8'h65;

  // 8XYn functions
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] GLYPHS [GLYPH_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [7:0]  random_byte;
    logic        key_down;
    logic [3:0]  key_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] program_counter;
    logic [15:0] executed_word;
    logic        sound_on;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [11:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       wr_res;
    logic       wr_flag;
  } alu_res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_DISP,
    ST_RD_MEM,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_RD_X,
    ST_RD_Y,
    ST_RD_V0,
    ST_EXEC,
    ST_RET,
    ST_WR_FLAG,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_BCD,
    ST_STORE_RD,
    ST_STORE_WR,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DONE
  } c8_state_t;

  // reset image of main memory: glyphs at the reset font base, rest zero
  function automatic logic [7:0] glyph_at(input logic [11:0] a);
    logic [11:0] off;
    off = a - FONT_RESET_BASE;
    if (a >= FONT_RESET_BASE && off < 12'(GLYPH_BYTES)) return GLYPHS[off[6:0]];
    return 8'h00;
  endfunction

  // {hundreds, tens, ones}, one nibble each
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  sub;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [3:0]  o;
    h   = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    sub = (h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0);
    r   = 7'(v - sub);
    p   = 15'(r) * 15'd205;
    t   = 4'(p >> 11);
    o   = 4'(r - 7'(t) * 7'd10);
    return {2'b00, h, t, o};
  endfunction

endpackage

// File: design/c8_stream_if.sv
interface c8_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/c8_alu.sv
module c8_alu (
  input  logic            [3:0] fn,
  input  logic            [7:0] a,
  input  logic            [7:0] b,
  input  logic                  shift_mode,
  output c8_pkg::alu_res_t      result
);
  import c8_pkg::*;

  logic [8:0] sum;
  logic [7:0] src;

  assign sum = {1'b0, a} + {1'b0, b};
  assign src = shift_mode ? a : b;

  always_comb begin
    result = '0;
    result.wr_res = 1'b1;
    case (fn)
      ALU_MOV: result.res = b;
      ALU_OR:  result.res = a | b;
      ALU_AND: result.res = a & b;
      ALU_XOR: result.res = a ^ b;
      ALU_ADD: begin
        result.res = sum[7:0];
        result.flag = sum[8];
        result.wr_flag = 1'b1;
      end
      ALU_SUB: begin
        result.res = a - b;
        result.flag = (a >= b);
        result.wr_flag = 1'b1;
      end
      ALU_SUBN: begin
        result.res = b - a;
        result.flag = (b >= a);
        result.wr_flag = 1'b1;
      end
      ALU_SHR: begin
        result.res = {1'b0, src[7:1]};
        result.flag = src[0];
        result.wr_flag = 1'b1;
      end
      ALU_SHL: begin
        result.res = {src[6:0], 1'b0};
        result.flag = src[7];
        result.wr_flag = 1'b1;
      end
      default: result.wr_res = 1'b0;
    endcase
  end
endmodule

// File: design/chip8_instruction_core_top.sv
// channel  role    payload       transfer
// cmd      sink    in_item_t     one item: load, execute, tick, key, read display, read memory
// rsp      source  out_item_t    one result per item, held in an output register
// cfg      sink    cfg_write_t   register write, always ready
//
// one item at a time; load, tick and key go straight to the final state, reads pass through a read state
// execute fetches the word and reads VX, VY and V0 before it executes; a VF write or a return
//   pop adds a state, BCD writes three digits, a draw reads and writes each row, and FX55/FX65
//   read and write each register from V0 to VX
// after reset a clearing pass writes all 4096 memory bytes (font glyphs, zeros)
// a waiting result stalls only the final state; the next item is accepted once it is loaded
module chip8_instruction_core_top #(
  parameter int STACK_DEPTH   = c8_pkg::STACK_DEPTH_DEF,
  parameter int PROGRAM_START = c8_pkg::PROGRAM_START_DEF
) (
  input  logic        clk,
  input  logic        rst,
  c8_stream_if.sink   cmd,
  c8_stream_if.source rsp,
  c8_stream_if.sink   cfg
);
  import c8_pkg::*;

  localparam int SIDX = $clog2(STACK_DEPTH);
  localparam int SCW  = $clog2(STACK_DEPTH + 1);

  // state machine and item context
  c8_state_t   state, state_next;
  in_item_t    item, item_next;
  logic [15:0] word, word_next;
  logic [7:0]  vx, vx_next, vy, vy_next, v0, v0_next;
  logic [7:0]  rd, rd_next;
  status_t     status, status_next;
  logic [3:0]  cnt, cnt_next;
  logic        coll, coll_next;
  logic        flag_q, flag_q_next;
  logic [11:0] bcd_q, bcd_q_next;
  logic [MEM_AW-1:0] clr_addr, clr_addr_next;

  // architectural registers
  logic [11:0]    pc, pc_next;
  logic [15:0]    idx, idx_next;
  logic [SCW-1:0] sc, sc_next;
  logic [7:0]     delay, delay_next, sound, sound_next;
  logic           key_flag, key_flag_next;
  logic [3:0]     key_code, key_code_next;
  logic           shift_mode, shift_mode_next, adv_mode, adv_mode_next;
  logic [11:0]    font_base, font_base_next;

  // output register
  logic      out_valid, out_valid_next;
  out_item_t out_q, out_q_next;

  // main memory
  logic [7:0]        mem [MEMORY_BYTES];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // data registers, valid bit per entry stands for the reset zero
  logic [7:0]  vreg [16];
  logic [15:0] v_valid;
  logic        v_we, v_rvalid;
  logic [3:0]  v_waddr, v_raddr;
  logic [7:0]  v_wdata, v_rdata, v_rd;

  // display rows, valid bit per row stands for pixels off
  logic [63:0]          disp [DISP_ROWS];
  logic [DISP_ROWS-1:0] d_valid;
  logic                 d_we, d_clear, d_rvalid;
  logic [4:0]           d_waddr, d_raddr;
  logic [63:0]          d_wdata, d_rdata, d_row;

  // return stack, never read above the count
  logic [11:0]     stk [STACK_DEPTH];
  logic            s_we;
  logic [SIDX-1:0] s_waddr, s_raddr;
  logic [11:0]     s_wdata, s_rdata;

  alu_res_t   alu;
  logic [5:0] draw_row;
  logic [63:0] sprite;
  logic [12:0] pc_plus2;
  logic        key_match;

  assign v_rd  = v_rvalid ? v_rdata : 8'h00;
  assign d_row = d_rvalid ? d_rdata : 64'h0;

  assign draw_row  = {1'b0, vy[4:0]} + {2'b00, cnt};
  assign sprite    = {mem_rdata, 56'h0} >> vx[5:0];
  assign pc_plus2  = {1'b0, pc} + 13'd2;
  assign key_match = key_flag && ({4'h0, key_code} == vx);

  c8_alu u_alu (
    .fn         (word[3:0]),
    .a          (vx),
    .b          (vy),
    .shift_mode (shift_mode),
    .result     (alu)
  );

  assign cmd.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;

  always_comb begin
    state_next      = state;
    item_next       = item;
    word_next       = word;
    vx_next         = vx;
    vy_next         = vy;
    v0_next         = v0;
    rd_next         = rd;
    status_next     = status;
    cnt_next        = cnt;
    coll_next       = coll;
    flag_q_next     = flag_q;
    bcd_q_next      = bcd_q;
    clr_addr_next   = clr_addr;
    pc_next         = pc;
    idx_next        = idx;
    sc_next         = sc;
    delay_next      = delay;
    sound_next      = sound;
    key_flag_next   = key_flag;
    key_code_next   = key_code;
    shift_mode_next = shift_mode;
    adv_mode_next   = adv_mode;
    font_base_next  = font_base;
    out_valid_next  = out_valid && !rsp.ready;
    out_q_next      = out_q;

    mem_we    = 1'b0;
    mem_waddr = idx[11:0] + 12'(cnt);
    mem_wdata = v_rd;
    mem_raddr = idx[11:0] + 12'(cnt);
    v_we      = 1'b0;
    v_waddr   = word[11:8];
    v_wdata   = 8'h00;
    v_raddr   = cnt;
    d_we      = 1'b0;
    d_clear   = 1'b0;
    d_waddr   = draw_row[4:0];
    d_wdata   = d_row ^ sprite;
    d_raddr   = draw_row[4:0];
    s_we      = 1'b0;
    s_waddr   = sc[SIDX-1:0];
    s_wdata   = pc;
    s_raddr   = SIDX'(sc - SCW'(1));

    // register writes are meant only while idle; the user must keep to this, the block does not enforce it
    if (cfg.valid) begin
      case (cfg.payload.index)
        CFG_SHIFT:   shift_mode_next = cfg.payload.value[0];
        CFG_ADVANCE: adv_mode_next   = cfg.payload.value[0];
        CFG_FONT:    font_base_next  = cfg.payload.value;
        default:     ;
      endcase
    end

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = glyph_at(clr_addr);
        clr_addr_next = clr_addr + MEM_AW'(1);
        if (clr_addr == MEM_AW'(MEMORY_BYTES - 1)) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        if (cmd.valid) begin
          item_next   = cmd.payload;
          rd_next     = 8'h00;
          word_next   = 16'h0000;
          status_next = STAT_OK;
          state_next  = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_next = ST_DONE;
        case (item.opcode)
          OP_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = item.address;
            mem_wdata = item.data;
          end
          OP_EXECUTE: state_next = ST_FETCH0;
          OP_TICK: begin
            if (delay != 8'h00) delay_next = delay - 8'd1;
            if (sound != 8'h00) sound_next = sound - 8'd1;
          end
          OP_KEY: begin
            if (item.key_down) begin
              key_flag_next = 1'b1;
              key_code_next = item.key_value;
            end else if (key_code == item.key_value) begin
              key_flag_next = 1'b0;
            end
          end
          OP_READ_DISP: begin
            d_raddr = item.address[7:3];
            if (item.address[11:8] == 4'h0) state_next = ST_RD_DISP;
          end
          OP_READ_MEM: begin
            mem_raddr  = item.address;
            state_next = ST_RD_MEM;
          end
          default: ;
        endcase
      end

      ST_RD_DISP: begin
        rd_next    = d_row[{~item.address[2:0], 3'b000} +: 8];
        state_next = ST_DONE;
      end

      ST_RD_MEM: begin
        rd_next    = mem_rdata;
        state_next = ST_DONE;
      end

      ST_FETCH0: begin
        mem_raddr  = pc;
        state_next = ST_FETCH1;
      end

      ST_FETCH1: begin
        word_next[15:8] = mem_rdata;
        mem_raddr       = pc + 12'd1;
        state_next      = ST_FETCH2;
      end

      ST_FETCH2: begin
        word_next[7:0] = mem_rdata;
        pc_next        = (pc_plus2 > {1'b0, PC_LAST}) ? PC_LAST : pc_plus2[11:0];
        v_raddr        = word[11:8];
        state_next     = ST_RD_X;
      end

      ST_RD_X: begin
        vx_next    = v_rd;
        v_raddr    = word[7:4];
        state_next = ST_RD_Y;
      end

      ST_RD_Y: begin
        vy_next    = v_rd;
        v_raddr    = 4'h0;
        state_next = ST_RD_V0;
      end

      ST_RD_V0: begin
        v0_next    = v_rd;
        state_next = ST_EXEC;
      end

      ST_EXEC: begin
        state_next = ST_DONE;
        cnt_next   = 4'h0;
        coll_next  = 1'b0;
        v_wdata    = word[7:0];
        case (word[15:12])
          G_SYS: begin
            if (word == W_CLS) begin
              d_clear = 1'b1;
            end else if (word == W_RET) begin
              if (sc == SCW'(0)) begin
                status_next = STAT_UNDERFLOW;
              end else begin
                sc_next    = sc - SCW'(1);
                state_next = ST_RET;
              end
            end
          end
          G_JP: pc_next = word[11:0];
          G_CALL: begin
            if (sc >= SCW'(STACK_DEPTH)) begin
              status_next = STAT_OVERFLOW;
            end else begin
              s_we    = 1'b1;
              sc_next = sc + SCW'(1);
              pc_next = word[11:0];
            end
          end
          G_SE_IMM:  if (vx == word[7:0]) pc_next = pc + 12'd2;
          G_SNE_IMM: if (vx != word[7:0]) pc_next = pc + 12'd2;
          G_SE_REG:  if (word[3:0] == 4'h0 && vx == vy) pc_next = pc + 12'd2;
          G_SNE_REG: if (word[3:0] == 4'h0 && vx != vy) pc_next = pc + 12'd2;
          G_LD_IMM:  v_we = 1'b1;
          G_ADD_IMM: begin
            v_we    = 1'b1;
            v_wdata = vx + word[7:0];
          end
          G_ALU: begin
            v_we        = alu.wr_res;
            v_wdata     = alu.res;
            flag_q_next = alu.flag;
            if (alu.wr_flag) state_next = ST_WR_FLAG;
          end
          G_LD_I:  idx_next = {4'h0, word[11:0]};
          G_JP_V0: pc_next = word[11:0] + {4'h0, v0};
          G_RND: begin
            v_we    = 1'b1;
            v_wdata = item.random_byte & word[7:0];
          end
          G_DRW: state_next = ST_DRAW_RD;
          G_KEY: begin
            if (word[7:0] == E_SKP && key_match) pc_next = pc + 12'd2;
            else if (word[7:0] == E_SKNP && !key_match) pc_next = pc + 12'd2;
          end
          G_MISC: begin
            case (word[7:0])
              F_LD_DT: begin
                v_we    = 1'b1;
                v_wdata = delay;
              end
              F_SET_DT: delay_next = vx;
              F_SET_ST: sound_next = vx;
              F_ADD_I: begin
                idx_next    = idx + {8'h00, vx};
                flag_q_next = (idx + {8'h00, vx}) > INDEX_LIMIT;
                state_next  = ST_WR_FLAG;
              end
              F_WAIT_KEY: begin
                if (key_flag) begin
                  v_we          = 1'b1;
                  v_wdata       = {4'h0, key_code};
                  key_flag_next = 1'b0;
                end else begin
                  pc_next     = pc - 12'd2;
                  status_next = STAT_KEY_WAIT;
                end
              end
              F_FONT: idx_next = {4'h0, font_base} + {10'h000, vx[3:0], 2'b00}
                                 + {12'h000, vx[3:0]};
              F_BCD: begin
                bcd_q_next = bcd_digits(vx);
                state_next = ST_BCD;
              end
              F_STORE: state_next = ST_STORE_RD;
              F_LOAD:  state_next = ST_LOAD_RD;
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      ST_RET: begin
        pc_next    = s_rdata;
        state_next = ST_DONE;
      end

      ST_WR_FLAG: begin
        v_we       = 1'b1;
        v_waddr    = VF_IDX;
        v_wdata    = {7'h00, flag_q};
        state_next = ST_DONE;
      end

      // one sprite row: read memory byte and display row, then xor back
      ST_DRAW_RD: begin
        if (cnt == word[3:0] || draw_row[5]) begin
          v_we       = 1'b1;
          v_waddr    = VF_IDX;
          v_wdata    = {7'h00, coll};
          state_next = ST_DONE;
        end else begin
          state_next = ST_DRAW_WR;
        end
      end

      ST_DRAW_WR: begin
        d_we       = 1'b1;
        coll_next  = coll | (|(d_row & sprite));
        cnt_next   = cnt + 4'd1;
        state_next = ST_DRAW_RD;
      end

      ST_BCD: begin
        mem_we = 1'b1;
        case (cnt)
          4'd0:    mem_wdata = {4'h0, bcd_q[11:8]};
          4'd1:    mem_wdata = {4'h0, bcd_q[7:4]};
          default: mem_wdata = {4'h0, bcd_q[3:0]};
        endcase
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd2) state_next = ST_DONE;
      end

      ST_STORE_RD: state_next = ST_STORE_WR;

      ST_STORE_WR: begin
        mem_we   = 1'b1;
        cnt_next = cnt + 4'd1;
        if (cnt == word[11:8]) begin
          if (adv_mode) idx_next = idx + {12'h000, word[11:8]};
          state_next = ST_DONE;
        end else begin
          state_next = ST_STORE_RD;
        end
      end

      ST_LOAD_RD: state_next = ST_LOAD_WR;

      ST_LOAD_WR: begin
        v_we     = 1'b1;
        v_waddr  = cnt;
        v_wdata  = mem_rdata;
        cnt_next = cnt + 4'd1;
        if (cnt == word[11:8]) begin
          if (adv_mode) idx_next = idx + {12'h000, word[11:8]};
          state_next = ST_DONE;
        end else begin
          state_next = ST_LOAD_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next             = 1'b1;
          out_q_next.read_data       = rd;
          out_q_next.program_counter = pc;
          out_q_next.executed_word   = word;
          out_q_next.sound_on        = (sound != 8'h00);
          out_q_next.status          = status;
          state_next                 = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      pc         <= 12'(PROGRAM_START);
      idx        <= 16'h0000;
      sc         <= '0;
      delay      <= 8'h00;
      sound      <= 8'h00;
      key_flag   <= 1'b0;
      key_code   <= 4'h0;
      shift_mode <= 1'b0;
      adv_mode   <= 1'b0;
      font_base  <= FONT_RESET_BASE;
      out_valid  <= 1'b0;
      v_valid    <= '0;
      d_valid    <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      pc         <= pc_next;
      idx        <= idx_next;
      sc         <= sc_next;
      delay      <= delay_next;
      sound      <= sound_next;
      key_flag   <= key_flag_next;
      key_code   <= key_code_next;
      shift_mode <= shift_mode_next;
      adv_mode   <= adv_mode_next;
      font_base  <= font_base_next;
      out_valid  <= out_valid_next;
      if (v_we) v_valid[v_waddr] <= 1'b1;
      if (d_clear) d_valid <= '0;
      else if (d_we) d_valid[d_waddr] <= 1'b1;
    end
  end

  // item context and result payload
  always_ff @(posedge clk) begin
    item   <= item_next;
    word   <= word_next;
    vx     <= vx_next;
    vy     <= vy_next;
    v0     <= v0_next;
    rd     <= rd_next;
    status <= status_next;
    cnt    <= cnt_next;
    coll   <= coll_next;
    flag_q <= flag_q_next;
    bcd_q  <= bcd_q_next;
    out_q  <= out_q_next;
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vreg[v_waddr] <= v_wdata;
    v_rdata  <= vreg[v_raddr];
    v_rvalid <= v_valid[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) disp[d_waddr] <= d_wdata;
    d_rdata  <= disp[d_raddr];
    d_rvalid <= d_valid[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) stk[s_waddr] <= s_wdata;
    s_rdata <= stk[s_raddr];
  end

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SCW'(STACK_DEPTH))
    else $error("return stack count beyond depth");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> state == ST_DISPATCH)
    else $error("accepted item did not start");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the final state");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !out_valid && !cmd.ready)
    else $error("activity during memory clearing pass");
`endif

endmodule
